// ===== sv/phtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtp_pkg
// shared types and constants of the position hash table probe unit
// ----------------------------------------------------------------------------
package phtp_pkg;

    localparam int TableEntries = 1024;
    localparam int ProbeLimit   = 8;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int CntW         = $clog2(ProbeLimit + 1);
    localparam int HalfW        = 50;
    localparam int KeyW         = 6 * HalfW + 1;
    localparam int QDepth       = 2;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [HalfW-1:0]  white_low;
        logic [HalfW-1:0]  white_high;
        logic [HalfW-1:0]  black_low;
        logic [HalfW-1:0]  black_high;
        logic [HalfW-1:0]  blocked_low;
        logic [HalfW-1:0]  blocked_high;
        logic              side_to_move;
        logic signed [15:0] score_in;
        logic [7:0]        search_depth_in;
        logic signed [15:0] alpha_in;
        logic signed [15:0] beta_in;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic signed [15:0] score_out;
        logic [7:0]        search_depth_out;
        logic signed [15:0] alpha_out;
        logic signed [15:0] beta_out;
        logic              overwrote;
    } t_rsp;

    // classified job handed from front to back
    typedef struct packed {
        t_mode             mode;
        logic [KeyW-1:0]   key;
        logic [IdxW-1:0]   home;
        logic [15:0]       score;
        logic [7:0]        depth;
        logic [15:0]       alpha;
        logic [15:0]       beta;
    } t_job;

    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [15:0]     score;
        logic [7:0]      depth;
        logic [15:0]     alpha;
        logic [15:0]     beta;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

// ===== sv/phtp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtp_req_if / phtp_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface phtp_req_if;
    logic            valid;
    logic            ready;
    phtp_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface phtp_rsp_if;
    logic            valid;
    logic            ready;
    phtp_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/phtp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtp_front
// accepts request beats, forms key and home slot, queues jobs for the back
// ----------------------------------------------------------------------------
module phtp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    phtp_req_if.sink          i_req,
    output logic              o_job_valid,
    output phtp_pkg::t_job    o_job,
    input  logic              i_job_ready
);
    import phtp_pkg::*;

    t_job              r_q [QDepth];
    logic [0:0]        r_wp, r_rp;
    logic [1:0]        r_cnt;
    t_job              n_job;
    logic [HalfW-1:0]  w_hash;
    logic              w_push, w_pop;

    assign w_hash = (i_req.data.white_high | i_req.data.black_high | i_req.data.blocked_high)
                  ^ (i_req.data.white_low | i_req.data.black_low | i_req.data.blocked_low);

    always_comb begin
        n_job.mode  = t_mode'(i_req.data.mode);
        n_job.key   = {i_req.data.white_low, i_req.data.white_high, i_req.data.black_low,
                       i_req.data.black_high, i_req.data.blocked_low,
                       i_req.data.blocked_high, i_req.data.side_to_move};
        n_job.home  = w_hash[IdxW-1:0];
        n_job.score = i_req.data.score_in;
        n_job.depth = i_req.data.search_depth_in;
        n_job.alpha = i_req.data.alpha_in;
        n_job.beta  = i_req.data.beta_in;
    end

    assign i_req.ready = (r_cnt != 2'(QDepth));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== sv/phtp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtp_back
// walks the probe sequence one slot per read, writes the table, forms results
// ----------------------------------------------------------------------------
module phtp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  phtp_pkg::t_job    i_job,
    output logic              o_job_ready,
    phtp_rsp_if.source        o_rsp
);
    import phtp_pkg::*;

    t_entry            r_mem [TableEntries];
    logic              r_vld [TableEntries];
    t_entry            r_rd;
    logic              r_rd_vld;

    t_state            r_state, n_state;
    t_job              r_job;
    logic [IdxW:0]     r_idx, n_idx;
    logic [CntW-1:0]   r_probes, n_probes;
    logic              r_found, n_found;
    t_rsp              r_rsp, n_rsp;
    logic              w_we;
    logic [IdxW-1:0]   w_waddr;
    t_entry            w_wdata;
    logic              w_vdata;
    logic              w_match, w_stop;
    t_entry            w_new;

    assign w_new = '{key: r_job.key, score: r_job.score, depth: r_job.depth,
                     alpha: r_job.alpha, beta: r_job.beta};
    assign w_match = r_rd.key == r_job.key;
    assign w_stop  = r_idx[IdxW] || (r_probes == CntW'(ProbeLimit));

    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[r_idx[IdxW-1:0]];
        r_rd_vld <= r_vld[r_idx[IdxW-1:0]];
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
            r_vld[w_waddr] <= w_vdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= (r_state == ST_IDLE) ? i_job : r_job;
        r_probes <= n_probes;
        r_found  <= n_found;
        r_rsp    <= n_rsp;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_probes = r_probes;
        n_found  = r_found;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_waddr  = r_job.home;
        w_wdata  = w_new;
        w_vdata  = 1'b1;
        o_job_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IdxW-1:0];
                w_vdata = 1'b0;
                n_idx   = r_idx + 1'b1;
                if (r_idx[IdxW-1:0] == IdxW'(TableEntries - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_idx    = {1'b0, i_job.home};
                    n_probes = '0;
                    n_found  = 1'b0;
                    n_rsp    = '0;
                    n_state  = (i_job.mode == MODE_NONE) ? ST_OUT : ST_READ;
                end
            end
            ST_READ: begin
                n_state = w_stop ? ST_WRITE : ST_CHECK;
            end
            ST_CHECK: begin
                if (!r_rd_vld) begin
                    n_state = ST_WRITE;
                end else if (r_job.mode != MODE_STORE && w_match) begin
                    n_found = 1'b1;
                    n_state = ST_WRITE;
                end else begin
                    n_idx    = r_idx + 1'b1;
                    n_probes = r_probes + 1'b1;
                    n_state  = ST_READ;
                end
            end
            ST_WRITE: begin
                n_state = ST_OUT;
                unique case (r_job.mode)
                    MODE_LOOKUP: begin
                        if (r_found) begin
                            n_rsp.hit              = 1'b1;
                            n_rsp.score_out        = r_rd.score;
                            n_rsp.search_depth_out = r_rd.depth;
                            n_rsp.alpha_out        = r_rd.alpha;
                            n_rsp.beta_out         = r_rd.beta;
                        end
                    end
                    MODE_UPDATE: begin
                        w_we = 1'b1;
                        if (r_found) begin
                            w_waddr       = r_idx[IdxW-1:0];
                            w_wdata       = r_rd;
                            w_wdata.score = r_job.score;
                            w_wdata.depth = r_job.depth;
                            n_rsp.hit     = 1'b1;
                        end else begin
                            n_rsp.overwrote = 1'b1;
                        end
                    end
                    MODE_STORE: begin
                        w_we = 1'b1;
                        if (!w_stop) begin
                            w_waddr = r_idx[IdxW-1:0];
                        end else begin
                            n_rsp.overwrote = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_OUT: begin
                if (o_rsp.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rsp.valid = (r_state == ST_OUT);
    assign o_rsp.data  = r_rsp;
endmodule

// ===== sv/position_hash_table_probe_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_hash_table_probe_unit
// linear probing hash table of board positions, lookup, store and update
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  i_req     in   mode, six key halves, side, score, depth, alpha, beta
//  o_rsp     out  hit, score, depth, alpha, beta, overwrote
//
//  each slot checked (1..8) takes a read and a check state; a walk that ends at the
//  probe limit or table end ends with a further read; then write and result states;
//  the unused mode goes straight to the result
//  a two-entry job queue lets new beats arrive while a result waits
//  after reset a pass over all 1024 slots clears the valid bits, jobs wait for it
//  the result holds until o_rsp.ready
// ----------------------------------------------------------------------------
module position_hash_table_probe_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phtp_req_if.sink    i_req,
    phtp_rsp_if.source  o_rsp
);
    import phtp_pkg::*;

    logic w_job_valid, w_job_ready;
    t_job w_job;

    phtp_front u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_job_valid(w_job_valid), .o_job(w_job), .i_job_ready(w_job_ready)
    );

    phtp_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .i_job(w_job), .o_job_ready(w_job_ready),
        .o_rsp
    );
endmodule

// ===== sv/phtp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtp_checker
// port level checks of the probe unit
// ----------------------------------------------------------------------------
module phtp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input phtp_pkg::t_rsp  rsp_data
);
    import phtp_pkg::*;

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && !req_ready |=> req_valid)
        else $error("request beat withdrawn");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result beat dropped or changed");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(rsp_data.hit && rsp_data.overwrote))
        else $error("hit and overwrote together");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_data.hit |-> rsp_data.score_out == 16'sd0 &&
        rsp_data.search_depth_out == 8'd0 && rsp_data.alpha_out == 16'sd0 &&
        rsp_data.beta_out == 16'sd0)
        else $error("fields set without hit");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid)
        else $error("result right after reset");
endmodule

bind position_hash_table_probe_unit phtp_checker u_checker (
    .i_clk, .i_rst_n,
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp_data(o_rsp.data)
);

// ===== bench/position_hash_table_probe_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_hash_table_probe_unit_tb
// drives lookup, store, update and unused-mode beats through the request
// channel, keeps a shadow copy of the table to predict every result, and
// checks each result beat field by field under random bursts on the sender
// and stalls on the receiver
// ----------------------------------------------------------------------------
module position_hash_table_probe_unit_tb;
    import phtp_pkg::*;

    logic i_clk;
    logic i_rst_n;

    phtp_req_if req_ch ();
    phtp_rsp_if rsp_ch ();

    position_hash_table_probe_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    typedef struct {
        logic [HalfW-1:0] k [6];
        logic             side;
        logic [15:0]      score;
        logic [7:0]       depth;
        logic [15:0]      alpha;
        logic [15:0]      beta;
    } t_slot;

    bit    shadow_valid [TableEntries];
    t_slot shadow_slot  [TableEntries];
    t_rsp  pending_rsp [$];
    int    mismatches;
    int    cycle_count;
    int    stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [IdxW-1:0] home_of(t_req r);
        logic [HalfW-1:0] h;
        h = (r.white_high | r.black_high | r.blocked_high)
          ^ (r.white_low | r.black_low | r.blocked_low);
        return h[IdxW-1:0];
    endfunction

    function automatic bit key_eq(int idx, t_req r);
        return shadow_slot[idx].k[0] == r.white_low && shadow_slot[idx].k[1] == r.white_high
            && shadow_slot[idx].k[2] == r.black_low && shadow_slot[idx].k[3] == r.black_high
            && shadow_slot[idx].k[4] == r.blocked_low
            && shadow_slot[idx].k[5] == r.blocked_high
            && shadow_slot[idx].side == r.side_to_move;
    endfunction

    function automatic void fill_slot(int idx, t_req r);
        shadow_valid[idx] = 1'b1;
        shadow_slot[idx].k[0] = r.white_low;
        shadow_slot[idx].k[1] = r.white_high;
        shadow_slot[idx].k[2] = r.black_low;
        shadow_slot[idx].k[3] = r.black_high;
        shadow_slot[idx].k[4] = r.blocked_low;
        shadow_slot[idx].k[5] = r.blocked_high;
        shadow_slot[idx].side = r.side_to_move;
        shadow_slot[idx].score = r.score_in;
        shadow_slot[idx].depth = r.search_depth_in;
        shadow_slot[idx].alpha = r.alpha_in;
        shadow_slot[idx].beta = r.beta_in;
    endfunction

    function automatic t_rsp probe_table(t_req r);
        t_rsp o;
        int   home;
        int   idx;
        int   probes;
        bit   found;
        o = '0;
        home = int'(home_of(r));
        idx = home;
        probes = 0;
        found = 0;
        if (r.mode == MODE_LOOKUP || r.mode == MODE_UPDATE) begin
            while (idx < TableEntries && shadow_valid[idx] && probes < ProbeLimit) begin
                if (key_eq(idx, r)) begin
                    found = 1;
                    break;
                end
                idx++;
                probes++;
            end
            if (r.mode == MODE_LOOKUP) begin
                if (found) begin
                    o.hit = 1'b1;
                    o.score_out = shadow_slot[idx].score;
                    o.search_depth_out = shadow_slot[idx].depth;
                    o.alpha_out = shadow_slot[idx].alpha;
                    o.beta_out = shadow_slot[idx].beta;
                end
            end else if (found) begin
                shadow_slot[idx].score = r.score_in;
                shadow_slot[idx].depth = r.search_depth_in;
                o.hit = 1'b1;
            end else begin
                fill_slot(home, r);
                o.overwrote = 1'b1;
            end
        end else if (r.mode == MODE_STORE) begin
            while (idx < TableEntries && shadow_valid[idx] && probes < ProbeLimit) begin
                idx++;
                probes++;
            end
            if (probes == ProbeLimit || idx >= TableEntries) begin
                idx = home;
                o.overwrote = 1'b1;
            end
            fill_slot(idx, r);
        end
        return o;
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= cycle_count[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 3);
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", rsp_ch.data);
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.data.hit !== e.hit || rsp_ch.data.score_out !== e.score_out
                    || rsp_ch.data.search_depth_out !== e.search_depth_out
                    || rsp_ch.data.alpha_out !== e.alpha_out
                    || rsp_ch.data.beta_out !== e.beta_out
                    || rsp_ch.data.overwrote !== e.overwrote) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p act %p", e, rsp_ch.data);
                end
            end
        end
    end

    task automatic send_beat(t_req r);
        req_ch.data <= r;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(probe_table(r));
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [HalfW-1:0] rand_half();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[HalfW-1:0];
    endfunction

    // key whose home slot is given, built from a random white_high
    function automatic t_req make_req(t_mode m, logic [IdxW-1:0] home);
        t_req r;
        r.mode = m;
        r.white_high = rand_half() & ~(50'h3FF);
        r.black_high = '0;
        r.blocked_high = '0;
        r.black_low = '0;
        r.blocked_low = '0;
        r.white_low = {r.white_high[HalfW-1:IdxW], home};
        r.side_to_move = 1'($urandom_range(0, 1));
        r.score_in = 16'($urandom());
        r.search_depth_in = 8'($urandom());
        r.alpha_in = 16'($urandom());
        r.beta_in = 16'($urandom());
        return r;
    endfunction

    function automatic t_req full_rand_req();
        t_req r;
        r.mode = 2'($urandom_range(0, 3));
        r.white_low = rand_half();
        r.white_high = rand_half();
        r.black_low = rand_half();
        r.black_high = rand_half();
        r.blocked_low = rand_half();
        r.blocked_high = rand_half();
        r.side_to_move = 1'($urandom_range(0, 1));
        r.score_in = 16'($urandom());
        r.search_depth_in = 8'($urandom());
        r.alpha_in = 16'($urandom());
        r.beta_in = 16'($urandom());
        return r;
    endfunction

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_req r;
        t_req s;
        r = make_req(MODE_LOOKUP, 10'd5);
        send_beat(r);
        r.mode = MODE_UPDATE;
        send_beat(r);
        r.mode = MODE_LOOKUP;
        send_beat(r);
        s = make_req(MODE_STORE, 10'd5);
        send_beat(s);
        s.mode = MODE_UPDATE;
        s.score_in = 16'sh7FFF;
        s.search_depth_in = 8'hFF;
        send_beat(s);
        s.mode = MODE_LOOKUP;
        send_beat(s);
        s.side_to_move = ~s.side_to_move;
        send_beat(s);
        // fill the probe window, then overflow it
        repeat (9) send_beat(make_req(MODE_STORE, 10'd100));
        // store near the table end
        repeat (3) send_beat(make_req(MODE_STORE, 10'd1023));
        r = full_rand_req();
        r.mode = MODE_NONE;
        send_beat(r);
        r = full_rand_req();
        r.mode = MODE_STORE;
        r.white_low = '1; r.white_high = '1; r.black_low = '1; r.black_high = '1;
        r.blocked_low = '1; r.blocked_high = '1;
        r.score_in = 16'sh8000; r.alpha_in = 16'sh8000; r.beta_in = 16'sh7FFF;
        send_beat(r);
        r.mode = MODE_LOOKUP;
        send_beat(r);
        wait_drained();
    endtask

    task automatic test_random();
        t_req pool [$];
        t_req r;
        int   sent;
        int   burst;
        int   sel;
        sent = 0;
        while (sent < 800) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                sel = $urandom_range(0, 9);
                if (sel == 0 || pool.size() == 0) begin
                    r = full_rand_req();
                end else if (sel < 4) begin
                    r = make_req(MODE_STORE,
                                 IdxW'($urandom_range(0, 63) + 960 * $urandom_range(0, 1)));
                    pool.push_back(r);
                    if (pool.size() > 64) void'(pool.pop_front());
                end else begin
                    r = pool[$urandom_range(0, pool.size() - 1)];
                    r.mode = (sel < 7) ? MODE_LOOKUP : MODE_UPDATE;
                    r.score_in = 16'($urandom());
                    r.search_depth_in = 8'($urandom());
                    if (sel == 9) r.side_to_move = ~r.side_to_move;
                end
                send_beat(r);
                sent++;
            end
            if (sent > 400 && sent < 420) wait_drained();
            idle_sender($urandom_range(0, 12));
        end
        wait_drained();
    endtask

    initial begin
        mismatches = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/phtp_pkg.sv
sv/phtp_if.sv
sv/phtp_front.sv
sv/phtp_back.sv
sv/position_hash_table_probe_unit.sv
sv/phtp_checker.sv
bench/position_hash_table_probe_unit_tb.sv
